// File: hdl/ber_oid_pkg.sv
// Shared types and constants for the BER object identifier encoder.
// Used by the front, queue, back and top-level modules; no dependencies.
package ber_oid_pkg;

  // Base-128 encoding constants
  localparam int SEPTET_BITS    = 7;
  localparam int MAX_SEPTETS    = 5;
  localparam int VALUE_BITS_MAX = SEPTET_BITS * MAX_SEPTETS;
  localparam logic [7:0] CONT_BIT = 8'h80;

  // Position of the next arc within the identifier
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_LATER  = 2'd2;

  // One classified arc, handed from front to back
  typedef struct packed {
    logic [VALUE_BITS_MAX-1:0] value;       // value to encode, zero extended
    logic [2:0]                septets;     // septets in the full encoding
    logic [2:0]                count;       // bytes actually emitted
    logic                      last;        // final arc of the identifier
    logic                      error;       // sticky error after this arc
    logic [15:0]               start_count; // bytes emitted before this arc
  } entry_t;

endpackage

// File: hdl/ber_oid_front.sv
// Front end: accepts arcs, forms the value to encode, sizes the output against
// the buffer limit and tracks identifier state. Depends on ber_oid_pkg.
module ber_oid_front #(
  parameter int ARC_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [15:0]           cfg_data,
  input  logic                  in_valid,
  input  logic [30:0]           in_arc,
  input  logic                  in_last,
  output logic                  in_ready,
  input  logic                  q_full,
  output logic                  q_push,
  output ber_oid_pkg::entry_t   q_entry
);

  localparam int VMAX = ber_oid_pkg::VALUE_BITS_MAX;
  localparam int VB   = (ARC_BITS < VMAX) ? ARC_BITS : VMAX;

  logic [15:0]   buffer_length;
  logic [1:0]    pos;
  logic [VB-1:0] held;
  logic [15:0]   byte_count;
  logic          err;

  logic          accept;
  logic [VB-1:0] arc_v;
  logic [VB-1:0] combined;
  logic [VB-1:0] value;
  logic          encode;
  logic [2:0]    septets;
  logic          blocked;
  logic [15:0]   room;
  logic          short_room;
  logic [2:0]    count;
  logic          err_next;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Form the value: first*40 + second as shift-add, later arcs as they come
  assign arc_v    = VB'(in_arc);
  assign combined = (held << 5) + (held << 3) + arc_v;
  assign value    = (pos == ber_oid_pkg::POS_SECOND) ? combined : arc_v;
  assign encode   = (pos != ber_oid_pkg::POS_FIRST);

  // Count significant septets
  always_comb begin
    septets = 3'd1;
    for (int i = 1; i < ber_oid_pkg::MAX_SEPTETS; i++) begin
      if ((value >> (ber_oid_pkg::SEPTET_BITS * i)) != '0) begin
        septets = 3'(i + 1);
      end
    end
  end

  // Clip byte count to the space left in the buffer
  assign blocked    = err || (buffer_length == 16'd0) || (byte_count >= buffer_length);
  assign room       = blocked ? 16'd0 : (buffer_length - byte_count);
  assign short_room = room < 16'(septets);
  assign count      = !encode ? 3'd0 : (short_room ? room[2:0] : septets);
  assign err_next   = err || (!encode && in_last) || (encode && short_room);

  // Queue entry: only arcs that emit bytes or close the identifier
  assign q_push              = accept && ((count != 3'd0) || in_last);
  assign q_entry.value       = VMAX'(value);
  assign q_entry.septets     = septets;
  assign q_entry.count       = count;
  assign q_entry.last        = in_last;
  assign q_entry.error       = err_next;
  assign q_entry.start_count = byte_count;

  // Hold the configured buffer length
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= 16'hFFFF;
    end else if (cfg_valid) begin
      buffer_length <= cfg_data;
    end
  end

  // Advance identifier state; drop it all after the last arc
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= ber_oid_pkg::POS_FIRST;
      byte_count <= 16'd0;
      err        <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        pos        <= ber_oid_pkg::POS_FIRST;
        byte_count <= 16'd0;
        err        <= 1'b0;
      end else begin
        pos        <= encode ? ber_oid_pkg::POS_LATER : ber_oid_pkg::POS_SECOND;
        byte_count <= byte_count + 16'(count);
        err        <= err_next;
      end
    end
  end

  // Hold the first arc for the combine step
  always_ff @(posedge clk) begin
    if (accept && (pos == ber_oid_pkg::POS_FIRST)) begin
      held <= arc_v;
    end
  end

endmodule

// File: hdl/ber_oid_queue.sv
// Short queue of classified arcs between front and back end.
// Depends on ber_oid_pkg for the entry type.
module ber_oid_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ber_oid_pkg::entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output ber_oid_pkg::entry_t head_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ber_oid_pkg::entry_t entries [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] cnt;

  assign full       = (cnt == CW'(DEPTH));
  assign head_valid = (cnt != '0);
  assign head_entry = entries[rptr];

  // Write the entry store
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (!push && pop) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Queue integrity
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> (!full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("queue fill count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (cnt == $past(cnt) + 1'b1))
    else $error("queue fill count missed a push");

endmodule

// File: hdl/ber_oid_back.sv
// Back end: walks each queued arc one septet per cycle into the output
// register, stalling while out_ready is low. Depends on ber_oid_pkg.
module ber_oid_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  ber_oid_pkg::entry_t head_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_byte_valid,
  output logic                out_last,
  output logic                out_error,
  output logic [15:0]         out_total
);

  logic [2:0] k;
  logic       load;
  logic       empty_arc;
  logic       final_byte;
  logic [2:0] idx;
  logic [6:0] septet;
  logic [7:0] enc_byte;

  assign load       = !out_valid || out_ready;
  assign empty_arc  = (head_entry.count == 3'd0);
  assign final_byte = (k == head_entry.count - 3'd1);
  assign idx        = head_entry.septets - 3'd1 - k;
  assign pop        = load && head_valid && (empty_arc || final_byte);

  // Pick the septet, most significant first
  always_comb begin
    case (idx)
      3'd0:    septet = head_entry.value[6:0];
      3'd1:    septet = head_entry.value[13:7];
      3'd2:    septet = head_entry.value[20:14];
      3'd3:    septet = head_entry.value[27:21];
      3'd4:    septet = head_entry.value[34:28];
      default: septet = 7'd0;
    endcase
  end

  assign enc_byte = {1'b0, septet} | ((idx != 3'd0) ? ber_oid_pkg::CONT_BIT : 8'h00);

  // Step through the bytes of the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= 3'd0;
    end else if (load && head_valid) begin
      k <= (empty_arc || final_byte) ? 3'd0 : k + 3'd1;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_error <= head_entry.error;
      if (empty_arc) begin
        out_byte       <= 8'h00;
        out_byte_valid <= 1'b0;
        out_last       <= 1'b1;
        out_total      <= head_entry.start_count;
      end else begin
        out_byte       <= enc_byte;
        out_byte_valid <= 1'b1;
        out_last       <= head_entry.last && final_byte;
        out_total      <= head_entry.start_count + 16'(k) + 16'd1;
      end
    end
  end

endmodule

// File: hdl/ber_object_identifier_encoder_unit.sv
// BER object identifier encoder: arcs in, base-128 bytes out, one byte per ready cycle.
// A result passes the queue and then the output register before it is offered.
// Throughput: arcs are taken every cycle until the four-entry queue fills; the output register
// sends one item per cycle while m_tready is high, one per emitted byte (up to five per arc)
// or one empty closing item. Reset (rst, synchronous): empties the queue, clears identifier
// state and sets buffer_length to 65535. Depends on ber_oid_pkg, front, queue, back.
module ber_object_identifier_encoder_unit #(
  parameter int ARC_BITS    = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write: buffer_length
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // arc input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] arc, [31] zero fill
  input  logic        s_tlast,   // last_arc
  // encoded result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] data_byte, [23:8] total_length
  output logic [1:0]  m_tuser,   // [0] byte_valid, [1] error
  output logic        m_tlast    // last_result
);

  ber_oid_pkg::entry_t push_entry;
  ber_oid_pkg::entry_t head_entry;
  logic                push;
  logic                full;
  logic                pop;
  logic                head_valid;

  assign cfg_ready = 1'b1;

  ber_oid_front #(
    .ARC_BITS (ARC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_arc    (s_tdata[30:0]),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .q_full    (full),
    .q_push    (push),
    .q_entry   (push_entry)
  );

  ber_oid_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  ber_oid_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_entry     (head_entry),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_byte       (m_tdata[7:0]),
    .out_byte_valid (m_tuser[0]),
    .out_last       (m_tlast),
    .out_error      (m_tuser[1]),
    .out_total      (m_tdata[23:8])
  );

endmodule
